// File: rtl/humidity_table_interpolator_defines.svh
// ----------------------------------------------------------------------------
// Humidity table interpolator assertion macros
// Shared concurrent assertion forms. The enclosing scope must provide clk and
// rst_n.
// ----------------------------------------------------------------------------
`ifndef HUMIDITY_TABLE_INTERPOLATOR_DEFINES_SVH
`define HUMIDITY_TABLE_INTERPOLATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HTI_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define HTI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/hti_pkg.sv
// ----------------------------------------------------------------------------
// Humidity table interpolator package
// Field widths, the calibration table and the types passed between the front
// end, the request queue and the divider back end.
// ----------------------------------------------------------------------------
`default_nettype none

package hti_pkg;

    // Payload widths.
    localparam int ADC_W       = 10;
    localparam int TEMP_W      = 11;
    localparam int HUM_W       = 15;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 16;

    // Calibration table geometry.
    localparam int ROWS  = 12;
    localparam int COLS  = 15;
    localparam int ROW_W = 4;
    localparam int COL_W = 4;

    // Row selection: the first row starts at 7.5 C, each later row 5 C on.
    localparam int ROW_T0   = 75;
    localparam int ROW_STEP = 50;

    // Humidity of the low end of column zero and the step per column, Q8.
    localparam int HUM_BASE     = 6400;
    localparam int HUM_COL_STEP = 1280;
    localparam int BASE_W       = 17;

    // Divider sizing: numerator is 1280 * (reading - entry), quotient bits.
    localparam int NUM_W = 21;
    localparam int QUO_W = 12;

    // Request queue between front and back.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    // Sensor readings per row, 20 %RH to 90 %RH in 5 %RH steps, 5 C to 60 C.
    localparam logic [ADC_W-1:0] HUM_TABLE [ROWS][COLS] = '{
        '{10'd0,    10'd1008, 10'd993, 10'd956, 10'd890, 10'd783, 10'd644, 10'd480,
          10'd339,  10'd223,  10'd138, 10'd83,  10'd48,  10'd27,  10'd15},
        '{10'd1013, 10'd1003, 10'd981, 10'd932, 10'd845, 10'd720, 10'd577, 10'd414,
          10'd286,  10'd183,  10'd117, 10'd71,  10'd43,  10'd25,  10'd15},
        '{10'd1010, 10'd995,  10'd964, 10'd902, 10'd798, 10'd654, 10'd499, 10'd361,
          10'd244,  10'd159,  10'd100, 10'd62,  10'd39,  10'd24,  10'd14},
        '{10'd1005, 10'd986,  10'd946, 10'd867, 10'd748, 10'd590, 10'd438, 10'd310,
          10'd206,  10'd133,  10'd89,  10'd55,  10'd35,  10'd22,  10'd14},
        '{10'd1000, 10'd975,  10'd926, 10'd829, 10'd694, 10'd533, 10'd380, 10'd256,
          10'd178,  10'd117,  10'd76,  10'd50,  10'd32,  10'd20,  10'd14},
        '{10'd993,  10'd962,  10'd902, 10'd787, 10'd634, 10'd460, 10'd343, 10'd232,
          10'd154,  10'd100,  10'd66,  10'd45,  10'd30,  10'd20,  10'd13},
        '{10'd987,  10'd946,  10'd875, 10'd743, 10'd577, 10'd414, 10'd300, 10'd201,
          10'd133,  10'd89,   10'd60,  10'd41,  10'd28,  10'd19,  10'd12},
        '{10'd979,  10'd932,  10'd848, 10'd701, 10'd533, 10'd378, 10'd264, 10'd173,
          10'd117,  10'd77,   10'd54,  10'd38,  10'd26,  10'd18,  10'd12},
        '{10'd972,  10'd919,  10'd822, 10'd662, 10'd480, 10'd339, 10'd236, 10'd154,
          10'd106,  10'd71,   10'd50,  10'd35,  10'd24,  10'd17,  10'd12},
        '{10'd966,  10'd902,  10'd794, 10'd624, 10'd438, 10'd307, 10'd210, 10'd138,
          10'd95,   10'd65,   10'd46,  10'd33,  10'd23,  10'd16,  10'd12},
        '{10'd959,  10'd892,  10'd771, 10'd590, 10'd414, 10'd279, 10'd192, 10'd128,
          10'd89,   10'd60,   10'd43,  10'd31,  10'd22,  10'd16,  10'd12},
        '{10'd956,  10'd882,  10'd753, 10'd563, 10'd391, 10'd260, 10'd173, 10'd117,
          10'd83,   10'd57,   10'd41,  10'd30,  10'd22,  10'd16,  10'd11}
    };

    // Classified request handed from the front end to the divider.
    typedef struct packed {
        logic [NUM_W-1:0] num;   // 1280 * (reading - lower entry)
        logic [ADC_W-1:0] dmag;  // magnitude of the entry difference
        logic             dneg;  // entry difference is negative
        logic [COL_W-1:0] col;   // matching column
        logic             oor;   // no column matched
    } cls_t;

    // One stage of the restoring divider.
    typedef struct packed {
        logic [NUM_W-1:0] rem;
        logic [QUO_W-1:0] quo;
        logic [ADC_W-1:0] dmag;
        logic             dneg;
        logic [COL_W-1:0] col;
        logic             oor;
    } div_stage_t;

endpackage

`default_nettype wire

// File: rtl/hti_front.sv
// ----------------------------------------------------------------------------
// Humidity table interpolator front end
// Accepts readings, picks the temperature row, finds the matching column and
// forms the numerator and divisor for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module hti_front (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          in_valid,
    output logic                         in_ready,
    input  wire  [hti_pkg::ADC_W-1:0]    adc,
    input  wire  [hti_pkg::TEMP_W-1:0]   temp,
    output logic                         q_valid,
    input  wire                          q_ready,
    output hti_pkg::cls_t                q_data
);

    logic                        a_valid_reg;
    logic                        a_valid_next;
    logic [hti_pkg::ADC_W-1:0]   a_adc_reg;
    logic [hti_pkg::ROW_W-1:0]   a_row_reg;
    logic [hti_pkg::ROW_W-1:0]   row_sel;

    logic [hti_pkg::ADC_W-1:0]   xrow [hti_pkg::COLS];
    logic [hti_pkg::COLS-2:0]    match;
    logic [hti_pkg::COL_W-1:0]   col;
    logic [hti_pkg::ADC_W-1:0]   xlo;
    logic [hti_pkg::ADC_W-1:0]   xhi;
    logic [hti_pkg::ADC_W-1:0]   diff;

    // The request stage advances when empty or when the queue takes its item.
    assign in_ready = !a_valid_reg || q_ready;

    always_comb
    begin
        a_valid_next = a_valid_reg;
        if (in_ready)
        begin
            a_valid_next = in_valid;
        end
    end

    // Row index: count of row thresholds that the temperature reaches.
    always_comb
    begin
        row_sel = '0;
        for (int k = 0; k < hti_pkg::ROWS - 1; k++)
        begin
            if ($signed(temp) >= $signed(hti_pkg::TEMP_W'(hti_pkg::ROW_T0
                                                          + hti_pkg::ROW_STEP * k)))
            begin
                row_sel = row_sel + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            a_adc_reg <= adc;
            a_row_reg <= row_sel;
        end
    end

    // Column search: the lowest column whose next entry is not above the reading.
    always_comb
    begin
        xrow = hti_pkg::HUM_TABLE[a_row_reg];
        for (int c = 0; c < hti_pkg::COLS - 1; c++)
        begin
            match[c] = a_adc_reg >= xrow[c + 1];
        end
        col = '0;
        for (int c = hti_pkg::COLS - 2; c >= 0; c--)
        begin
            if (match[c])
            begin
                col = hti_pkg::COL_W'(c);
            end
        end
    end

    // Numerator and signed divisor of the interpolation.
    always_comb
    begin
        xhi  = xrow[col];
        xlo  = xrow[hti_pkg::COL_W'(col + 1'b1)];
        diff = a_adc_reg - xlo;

        q_data.col  = col;
        q_data.oor  = ~|match;
        q_data.dneg = xhi < xlo;
        q_data.dmag = (xhi < xlo) ? (xlo - xhi) : (xhi - xlo);
        q_data.num  = hti_pkg::NUM_W'({diff, 10'b0}) + hti_pkg::NUM_W'({diff, 8'b0});
        if (~|match)
        begin
            q_data.num = '0;
        end
    end

    assign q_valid = a_valid_reg;

endmodule

`default_nettype wire

// File: rtl/hti_fifo.sv
// ----------------------------------------------------------------------------
// Humidity table interpolator request queue
// Short register queue that lets the front end and the divider stall apart.
// ----------------------------------------------------------------------------
`default_nettype none

module hti_fifo (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  wr_valid,
    output logic                 wr_ready,
    input  wire hti_pkg::cls_t   wr_data,
    output logic                 rd_valid,
    input  wire                  rd_ready,
    output hti_pkg::cls_t        rd_data
);

    hti_pkg::cls_t                   mem_reg [hti_pkg::FIFO_DEPTH];
    logic [hti_pkg::FIFO_AW-1:0]     wr_ptr_reg;
    logic [hti_pkg::FIFO_AW-1:0]     wr_ptr_next;
    logic [hti_pkg::FIFO_AW-1:0]     rd_ptr_reg;
    logic [hti_pkg::FIFO_AW-1:0]     rd_ptr_next;
    logic [hti_pkg::FIFO_AW:0]       count_reg;
    logic [hti_pkg::FIFO_AW:0]       count_next;
    logic                            push;
    logic                            pop;

    assign wr_ready = count_reg != (hti_pkg::FIFO_AW + 1)'(hti_pkg::FIFO_DEPTH);
    assign rd_valid = count_reg != '0;
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// File: rtl/hti_back.sv
// ----------------------------------------------------------------------------
// Humidity table interpolator back end
// Pipelined restoring divider, one quotient bit per stage, followed by the
// humidity offset and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module hti_back (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        q_valid,
    output logic                       q_ready,
    input  wire hti_pkg::cls_t         q_data,
    output logic                       out_valid,
    input  wire                        out_ready,
    output logic [hti_pkg::HUM_W-1:0]  humidity,
    output logic                       oor
);

    localparam int N = hti_pkg::QUO_W;

    logic                           adv;
    logic [N:0]                     valid_reg;
    logic [N:0]                     valid_next;
    hti_pkg::div_stage_t            stage_reg  [N+1];
    hti_pkg::div_stage_t            stage_next [N];
    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic [hti_pkg::HUM_W-1:0]      hum_reg;
    logic                           oor_reg;
    logic [hti_pkg::BASE_W-1:0]     base;
    logic signed [hti_pkg::BASE_W:0] hum_full;
    logic [hti_pkg::HUM_W-1:0]      hum_final;

    // The whole pipeline moves unless a finished result is waiting.
    assign adv     = !out_valid_reg || out_ready;
    assign q_ready = adv;

    always_comb
    begin
        valid_next     = adv ? {valid_reg[N-1:0], q_valid} : valid_reg;
        out_valid_next = adv ? valid_reg[N] : out_valid_reg;
    end

    // One quotient bit per stage, most significant first.
    for (genvar g = 0; g < N; g++)
    begin : g_div
        localparam int B = N - 1 - g;
        logic [hti_pkg::NUM_W-1:0] trial;

        always_comb
        begin
            trial         = {{(hti_pkg::NUM_W - hti_pkg::ADC_W){1'b0}}, stage_reg[g].dmag} << B;
            stage_next[g] = stage_reg[g];
            if (stage_reg[g].rem >= trial)
            begin
                stage_next[g].rem    = stage_reg[g].rem - trial;
                stage_next[g].quo[B] = 1'b1;
            end
        end
    end

    // Humidity = column base - signed quotient, floored at 0; 0 if oor.
    always_comb
    begin
        base = hti_pkg::BASE_W'(hti_pkg::HUM_BASE)
             + hti_pkg::BASE_W'({stage_reg[N].col, 10'b0})
             + hti_pkg::BASE_W'({stage_reg[N].col, 8'b0});
        if (stage_reg[N].dneg)
        begin
            hum_full = $signed({1'b0, base}) + $signed({6'b0, stage_reg[N].quo});
        end
        else
        begin
            hum_full = $signed({1'b0, base}) - $signed({6'b0, stage_reg[N].quo});
        end
        if (stage_reg[N].oor || hum_full[hti_pkg::BASE_W])
        begin
            hum_final = '0;
        end
        else
        begin
            hum_final = hum_full[hti_pkg::HUM_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Stage payloads and the result register.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            stage_reg[0].rem  <= q_data.num;
            stage_reg[0].quo  <= '0;
            stage_reg[0].dmag <= q_data.dmag;
            stage_reg[0].dneg <= q_data.dneg;
            stage_reg[0].col  <= q_data.col;
            stage_reg[0].oor  <= q_data.oor;
            for (int i = 0; i < N; i++)
            begin
                stage_reg[i+1] <= stage_next[i];
            end
            hum_reg <= hum_final;
            oor_reg <= stage_reg[N].oor;
        end
    end

    assign out_valid = out_valid_reg;
    assign humidity  = hum_reg;
    assign oor       = oor_reg;

endmodule

`default_nettype wire

// File: rtl/humidity_table_interpolator.sv
// Path: a request passes the front stage, the queue, 12 pipelined divider
// stages of one quotient bit each and the output register.
// Throughput: one request per cycle while the output is not stalled.
// Reset: rst_n clears all valid bits and queue pointers at once; no table
// or memory clearing is needed.
// ----------------------------------------------------------------------------
// Humidity table interpolator
// Converts a resistive humidity reading and a temperature into relative
// humidity by linear interpolation in a temperature-selected calibration row.
// ----------------------------------------------------------------------------
`default_nettype none

module humidity_table_interpolator (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               s_axis_tvalid,
    output logic                              s_axis_tready,
    // [9:0] adc_reading, [20:10] temperature_tenths, [23:21] zero
    input  wire  [hti_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  wire                               m_axis_tready,
    // [14:0] humidity_q8, [15] zero
    output logic [hti_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // [0] out_of_range
    output logic [0:0]                        m_axis_tuser
);

    logic                          q_in_valid;
    logic                          q_in_ready;
    hti_pkg::cls_t                 q_in_data;
    logic                          q_out_valid;
    logic                          q_out_ready;
    hti_pkg::cls_t                 q_out_data;
    logic [hti_pkg::HUM_W-1:0]     humidity;
    logic                          oor;

    // Front end: row and column classification.
    hti_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .adc      (s_axis_tdata[hti_pkg::ADC_W-1:0]),
        .temp     (s_axis_tdata[hti_pkg::ADC_W+hti_pkg::TEMP_W-1:hti_pkg::ADC_W]),
        .q_valid  (q_in_valid),
        .q_ready  (q_in_ready),
        .q_data   (q_in_data)
    );

    // Request queue between the two halves.
    hti_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (q_in_valid),
        .wr_ready (q_in_ready),
        .wr_data  (q_in_data),
        .rd_valid (q_out_valid),
        .rd_ready (q_out_ready),
        .rd_data  (q_out_data)
    );

    // Back end: divider and output register.
    hti_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_out_valid),
        .q_ready   (q_out_ready),
        .q_data    (q_out_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .humidity  (humidity),
        .oor       (oor)
    );

    assign m_axis_tdata = {{(hti_pkg::OUT_TDATA_W - hti_pkg::HUM_W){1'b0}}, humidity};
    assign m_axis_tuser = oor;

endmodule

`default_nettype wire

// File: rtl/hti_checker.sv
// ----------------------------------------------------------------------------
// Humidity table interpolator port checker
// Watches the result port for range, flag consistency and stall behavior.
// ----------------------------------------------------------------------------
`default_nettype none

`include "humidity_table_interpolator_defines.svh"

module hti_checker (
    input wire                              clk,
    input wire                              rst_n,
    input wire                              m_axis_tvalid,
    input wire                              m_axis_tready,
    input wire [hti_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    input wire [0:0]                        m_axis_tuser
);

    // An out-of-range result always carries zero humidity.
    `HTI_ASSERT_NOW(a_oor_zero, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata == '0, "out of range result with nonzero humidity")

    // Humidity never exceeds the top of the table, 90 %RH in Q8.
    `HTI_ASSERT_NOW(a_hum_range, m_axis_tvalid, m_axis_tdata <= 16'd23040, "humidity above 90 percent")

    // A stalled result stays offered.
    `HTI_ASSERT_NEXT(a_valid_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result withdrawn while stalled")

    // A stalled result keeps its value.
    `HTI_ASSERT_NEXT(a_data_hold, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

endmodule

bind humidity_table_interpolator hti_checker u_hti_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// File: tb/humidity_table_interpolator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Humidity table interpolator testbench
// Sends requests made of a sensor reading and a temperature, works out the
// expected humidity with its own copy of the calibration table, and checks
// every result in order. Both stream sides idle at random.
// ----------------------------------------------------------------------------

module humidity_table_interpolator_tb;

    import hti_pkg::ADC_W;
    import hti_pkg::TEMP_W;
    import hti_pkg::HUM_W;
    import hti_pkg::IN_TDATA_W;
    import hti_pkg::OUT_TDATA_W;

    // Calibration table geometry and row rounding, temperatures in tenths.
    localparam int CAL_ROWS    = 12;
    localparam int CAL_COLS    = 15;
    localparam int FIRST_ROW_T = 75;
    localparam int ROW_SPAN_T  = 50;
    localparam int ROW_ROUND_T = 25;
    localparam int RANDOM_REQS = 900;
    localparam int DRAIN_WAIT  = 40;

    // Sensor readings per row, 20 %RH to 90 %RH, rows from 5 C to 60 C.
    localparam logic [ADC_W-1:0] CAL_READINGS [CAL_ROWS][CAL_COLS] = '{
        '{0, 1008, 993, 956, 890, 783, 644, 480, 339, 223, 138, 83, 48, 27, 15},
        '{1013, 1003, 981, 932, 845, 720, 577, 414, 286, 183, 117, 71, 43, 25, 15},
        '{1010, 995, 964, 902, 798, 654, 499, 361, 244, 159, 100, 62, 39, 24, 14},
        '{1005, 986, 946, 867, 748, 590, 438, 310, 206, 133, 89, 55, 35, 22, 14},
        '{1000, 975, 926, 829, 694, 533, 380, 256, 178, 117, 76, 50, 32, 20, 14},
        '{993, 962, 902, 787, 634, 460, 343, 232, 154, 100, 66, 45, 30, 20, 13},
        '{987, 946, 875, 743, 577, 414, 300, 201, 133, 89, 60, 41, 28, 19, 12},
        '{979, 932, 848, 701, 533, 378, 264, 173, 117, 77, 54, 38, 26, 18, 12},
        '{972, 919, 822, 662, 480, 339, 236, 154, 106, 71, 50, 35, 24, 17, 12},
        '{966, 902, 794, 624, 438, 307, 210, 138, 95, 65, 46, 33, 23, 16, 12},
        '{959, 892, 771, 590, 414, 279, 192, 128, 89, 60, 43, 31, 22, 16, 12},
        '{956, 882, 753, 563, 391, 260, 173, 117, 83, 57, 41, 30, 22, 16, 11}
    };

    typedef struct packed {
        logic [HUM_W-1:0] humidity_q8;
        logic             out_of_range;
    } humidity_result_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [0:0]             m_axis_tuser;

    humidity_result_t pending_humidity [$];
    int               mismatches = 0;
    bit               sender_steady = 1'b0;
    bit               receiver_steady = 1'b0;
    int               stall_left = 0;

    humidity_table_interpolator dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Expected humidity: pick the rounded temperature row, then interpolate in
    // the first column whose lower entry is not above the reading.
    function automatic humidity_result_t interpolate_humidity(
        input logic [ADC_W-1:0]         reading,
        input logic signed [TEMP_W-1:0] temp_tenths
    );
        humidity_result_t res;
        int               t;
        int               rd;
        int               row;
        int               xlo;
        int               xhi;
        int               quot;
        int               hum;
        bit               found;
        t = temp_tenths;
        rd = reading;
        if (t < FIRST_ROW_T)
        begin
            row = 0;
        end
        else
        begin
            row = (t + ROW_ROUND_T) / ROW_SPAN_T;
            if (row > CAL_ROWS)
                row = CAL_ROWS;
            row = row - 1;
        end
        res.humidity_q8 = '0;
        res.out_of_range = 1'b1;
        found = 1'b0;
        for (int c = 0; c < CAL_COLS - 1; c++)
        begin
            xlo = CAL_READINGS[row][c + 1];
            xhi = CAL_READINGS[row][c];
            if (!found && rd >= xlo)
            begin
                // Signed division truncates toward zero, which covers the
                // negative span next to the zero entry of the coldest row.
                quot = (1280 * (rd - xlo)) / (xhi - xlo);
                hum = 256 * (25 + 5 * c) - quot;
                if (hum < 0)
                    hum = 0;
                res.humidity_q8 = hum[HUM_W-1:0];
                res.out_of_range = 1'b0;
                found = 1'b1;
            end
        end
        return res;
    endfunction

    // Idle length: mostly none or short, now and then long.
    function automatic int draw_idle();
        int pick;
        pick = $urandom_range(99, 0);
        if (pick < 40)
            return 0;
        else if (pick < 85)
            return $urandom_range(3, 1);
        else if (pick < 97)
            return $urandom_range(10, 4);
        else
            return $urandom_range(60, 20);
    endfunction

    // Sends one request; entered and left at a falling edge.
    task automatic send_reading(
        input logic [ADC_W-1:0]         reading,
        input logic signed [TEMP_W-1:0] temp_tenths
    );
        int idle;
        idle = sender_steady ? 0 : draw_idle();
        if (idle > 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat (idle) @(negedge clk);
        end
        s_axis_tdata = {{(IN_TDATA_W - ADC_W - TEMP_W){1'b0}}, temp_tenths, reading};
        s_axis_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_humidity.push_back(interpolate_humidity(reading, temp_tenths));
        @(negedge clk);
    endtask

    // Rounding at three row boundaries, coldest and hottest codes included.
    task automatic test_row_selection();
        send_reading(10'd500, -11'sd1024);
        send_reading(10'd500, -11'sd400);
        send_reading(10'd500, 11'sd0);
        send_reading(10'd500, 11'sd74);
        send_reading(10'd500, 11'sd75);
        send_reading(10'd500, 11'sd124);
        send_reading(10'd500, 11'sd125);
        send_reading(10'd500, 11'sd574);
        send_reading(10'd500, 11'sd575);
        send_reading(10'd500, 11'sd600);
        send_reading(10'd500, 11'sd850);
        send_reading(10'd500, 11'sd1023);
    endtask

    // Lowest and highest readings, including extrapolation past column zero.
    task automatic test_reading_extremes();
        send_reading(10'd0, 11'sd250);
        send_reading(10'd1023, 11'sd250);
        send_reading(10'd1023, 11'sd600);
        send_reading(10'd0, 11'sd50);
    endtask

    // Zero entry of the coldest row and readings at and below the last entry.
    task automatic test_table_corners();
        send_reading(10'd1008, 11'sd50);
        send_reading(10'd1015, 11'sd50);
        send_reading(10'd1023, 11'sd50);
        send_reading(10'd15, 11'sd50);
        send_reading(10'd14, 11'sd50);
        send_reading(10'd11, 11'sd600);
        send_reading(10'd10, 11'sd600);
    endtask

    // Random requests in phases with and without idling on either side.
    task automatic test_random_readings();
        int                       pick;
        int                       row;
        int                       col;
        int                       reading;
        logic signed [TEMP_W-1:0] temp_tenths;
        for (int n = 0; n < RANDOM_REQS; n++)
        begin
            if (n % 150 == 0)
            begin
                sender_steady = ($urandom_range(2, 0) == 0);
                receiver_steady = ($urandom_range(2, 0) == 0);
            end
            pick = $urandom_range(9, 0);
            if (pick < 6)
            begin
                reading = $urandom_range(1023, 0);
                temp_tenths = $urandom_range(850, 0) - 400;
            end
            else if (pick < 8)
            begin
                // Close to a table entry, with a temperature inside that row.
                row = $urandom_range(CAL_ROWS - 1, 0);
                col = $urandom_range(CAL_COLS - 1, 0);
                reading = CAL_READINGS[row][col] + $urandom_range(4, 0) - 2;
                if (reading < 0)
                    reading = 0;
                if (reading > 1023)
                    reading = 1023;
                temp_tenths = ROW_SPAN_T * (row + 1) + $urandom_range(49, 0) - ROW_ROUND_T;
            end
            else if (pick < 9)
            begin
                reading = $urandom_range(1023, 0);
                temp_tenths = $urandom_range(2047, 0);
            end
            else
            begin
                // Around the last entries, where results run out of range.
                reading = $urandom_range(20, 0);
                temp_tenths = $urandom_range(850, 0) - 400;
            end
            send_reading(reading[ADC_W-1:0], temp_tenths);
        end
        sender_steady = 1'b0;
        receiver_steady = 1'b0;
    endtask

    // Result side ready, with random stalls.
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                m_axis_tready = 1'b0;
                stall_left--;
            end
            else
            begin
                m_axis_tready = 1'b1;
                if (!receiver_steady && $urandom_range(3, 0) == 0)
                    stall_left = draw_idle();
            end
        end
    end

    // Compare every accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        humidity_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_humidity.size() == 0)
            begin
                $error("unexpected result: humidity_q8 %0d out_of_range %0d",
                       m_axis_tdata[HUM_W-1:0], m_axis_tuser[0]);
                mismatches++;
            end
            else
            begin
                want = pending_humidity.pop_front();
                if (m_axis_tdata[HUM_W-1:0] !== want.humidity_q8)
                begin
                    $error("humidity_q8: expected %0d, actual %0d",
                           want.humidity_q8, m_axis_tdata[HUM_W-1:0]);
                    mismatches++;
                end
                if (m_axis_tuser[0] !== want.out_of_range)
                begin
                    $error("out_of_range: expected %0d, actual %0d",
                           want.out_of_range, m_axis_tuser[0]);
                    mismatches++;
                end
            end
        end
    end

    // Test sequence.
    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_row_selection();
        test_reading_extremes();
        test_table_corners();
        test_random_readings();
        s_axis_tvalid = 1'b0;
        while (pending_humidity.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatches == 0 && pending_humidity.size() == 0)
            $display("humidity_table_interpolator_tb: clean");
        else
            $display("humidity_table_interpolator_tb: errors");
        $finish;
    end

    // Run limit, far above the slowest correct run.
    initial
    begin
        #10_000_000;
        $display("humidity_table_interpolator_tb: errors");
        $finish;
    end

endmodule
